// ===== hdl/hrsp_pkg.sv =====
// Shared types and constants for the hex record stream parser.
`default_nettype none

package hrsp_pkg;

  // Character codes
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  // Highest legal record type
  localparam logic [7:0] MAX_REC_TYPE = 8'h05;

  // Record types
  localparam logic [7:0] REC_DATA     = 8'h00;
  localparam logic [7:0] REC_SEG_ADDR = 8'h02;
  localparam logic [7:0] REC_SEG_EXEC = 8'h03;
  localparam logic [7:0] REC_LIN_ADDR = 8'h04;
  localparam logic [7:0] REC_LIN_EXEC = 8'h05;

  // Statistic limit
  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  // Line error codes
  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_NO_COLON = 3'd1,
    ERR_BAD_HEX  = 3'd2,
    ERR_SHORT    = 3'd3,
    ERR_TYPE     = 3'd4,
    ERR_CHECKSUM = 3'd5
  } line_err_t;

  // Result kinds
  localparam logic RESULT_DATA   = 1'b0;
  localparam logic RESULT_REPORT = 1'b1;

  // Events from the line parser to the file statistics unit
  typedef struct packed {
    logic             data_valid;
    logic             end_valid;
    line_err_t        error;
    logic [7:0]       kind;
    logic [7:0]       length;
    logic [15:0]      offset;
    logic [7:0]       index;
    logic [7:0]       data;
    logic [3:0][7:0]  lead;
  } line_evt_t;

endpackage

`default_nettype wire

// ===== hdl/hex_record_stream_parser.sv =====
// Top level of the hex record stream parser: input stage, parser, output register.
//
// Usage: hex text enters one character per transaction on the input channel
// (in_valid/in_ready, char_code, new_file). new_file clears base address and
// statistics before its character is handled; a line in progress continues.
// The output channel (out_valid/out_ready) carries at most one result per
// character: a data byte with its absolute address (result_kind 0) or, at
// each LF ending a non-blank line, a record report (result_kind 1) with type,
// pass/fail, error code and the running statistics.
// A result passes through the input register, then the output register, after its
// character is accepted. Throughput: one character per cycle while the receiver
// does not stall; the single decode step between the two registers sets that rate.
// When the receiver stalls, the output register holds its result and the
// input register takes one more character, after which in_ready drops.
// Reset clears the line state and statistics; no result is pending after it.
`default_nettype none

module hex_record_stream_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  char_code,
  input  wire logic        new_file,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             result_kind,
  output logic [7:0]       data_byte,
  output logic [31:0]      byte_address,
  output logic [7:0]       record_type,
  output logic             record_ok,
  output logic [2:0]       error_code,
  output logic [31:0]      range_start,
  output logic [31:0]      range_end,
  output logic [31:0]      entry_address,
  output logic             entry_valid,
  output logic [31:0]      data_records,
  output logic [31:0]      data_bytes
);
  import hrsp_pkg::*;

  logic        s1_valid;
  logic [7:0]  s1_char;
  logic        s1_new_file;
  logic        advance;
  logic        step;
  line_evt_t   evt;

  logic        st_ok;
  logic [31:0] st_address, st_start, st_end, st_entry, st_records, st_bytes;
  logic        st_entry_valid;

  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;
  assign step     = s1_valid && advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_char     <= char_code;
      s1_new_file <= new_file;
    end
  end

  hrsp_line_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .char_code (s1_char),
    .evt       (evt)
  );

  hrsp_file_stats u_stats (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .new_file      (s1_new_file),
    .evt           (evt),
    .record_ok     (st_ok),
    .byte_address  (st_address),
    .range_start   (st_start),
    .range_end     (st_end),
    .entry_address (st_entry),
    .entry_valid   (st_entry_valid),
    .data_records  (st_records),
    .data_bytes    (st_bytes)
  );

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= step && (evt.data_valid || evt.end_valid);
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (step && (evt.data_valid || evt.end_valid)) begin
      record_type <= evt.kind;
      if (evt.end_valid) begin
        result_kind   <= RESULT_REPORT;
        data_byte     <= 8'd0;
        byte_address  <= 32'd0;
        record_ok     <= st_ok;
        error_code    <= evt.error;
        range_start   <= st_start;
        range_end     <= st_end;
        entry_address <= st_entry;
        entry_valid   <= st_entry_valid;
        data_records  <= st_records;
        data_bytes    <= st_bytes;
      end else begin
        result_kind   <= RESULT_DATA;
        data_byte     <= evt.data;
        byte_address  <= st_address;
        record_ok     <= 1'b0;
        error_code    <= ERR_NONE;
        range_start   <= 32'd0;
        range_end     <= 32'd0;
        entry_address <= 32'd0;
        entry_valid   <= 1'b0;
        data_records  <= 32'd0;
        data_bytes    <= 32'd0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/hrsp_line_parser.sv =====
// Per-line record field decoder: phase tracking, nibble pairing, checksum.
`default_nettype none

module hrsp_line_parser (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire logic [7:0]        char_code,
  output hrsp_pkg::line_evt_t    evt
);
  import hrsp_pkg::*;

  typedef enum logic [14:0] {
    PH_WAIT    = 15'h0001,
    PH_CNT_HI  = 15'h0002,
    PH_CNT_LO  = 15'h0004,
    PH_AH_HI   = 15'h0008,
    PH_AH_LO   = 15'h0010,
    PH_AL_HI   = 15'h0020,
    PH_AL_LO   = 15'h0040,
    PH_TYP_HI  = 15'h0080,
    PH_TYP_LO  = 15'h0100,
    PH_DAT_HI  = 15'h0200,
    PH_DAT_LO  = 15'h0400,
    PH_SUM_HI  = 15'h0800,
    PH_SUM_LO  = 15'h1000,
    PH_DONE    = 15'h2000,
    PH_ERROR   = 15'h4000
  } phase_t;

  phase_t          phase, phase_next;
  logic [3:0]      nibble_hold, nibble_hold_next;
  logic [7:0]      rec_length, rec_length_next;
  logic [15:0]     rec_offset, rec_offset_next;
  logic [7:0]      rec_kind, rec_kind_next;
  logic [7:0]      byte_index, byte_index_next;
  logic [7:0]      running_sum, running_sum_next;
  line_err_t       line_error, line_error_next;
  logic            line_seen, line_seen_next;
  logic [3:0][7:0] leading_bytes, leading_bytes_next;

  logic            is_ws;
  logic            hex_ok;
  logic [3:0]      hex_val;
  logic [7:0]      byte_val;
  logic [7:0]      sum_new;
  logic [8:0]      idx_inc;

  // Hex digit decode
  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (char_code >= 8'h30 && char_code <= 8'h39) begin
      hex_val = char_code[3:0];
    end else if ((char_code >= 8'h41 && char_code <= 8'h46) ||
                 (char_code >= 8'h61 && char_code <= 8'h66)) begin
      hex_val = char_code[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign is_ws    = (char_code == CHAR_SPACE) || (char_code == CHAR_TAB) ||
                    (char_code == CHAR_CR);
  assign byte_val = {nibble_hold, hex_val};
  assign sum_new  = running_sum + byte_val;
  assign idx_inc  = {1'b0, byte_index} + 9'd1;

  // Event fields always reflect the current line
  always_comb begin
    evt.data_valid = 1'b0;
    evt.end_valid  = 1'b0;
    evt.error      = line_error;
    evt.kind       = rec_kind;
    evt.length     = rec_length;
    evt.offset     = rec_offset;
    evt.index      = byte_index;
    evt.data       = byte_val;
    evt.lead       = leading_bytes;

    phase_next         = phase;
    nibble_hold_next   = nibble_hold;
    rec_length_next    = rec_length;
    rec_offset_next    = rec_offset;
    rec_kind_next      = rec_kind;
    byte_index_next    = byte_index;
    running_sum_next   = running_sum;
    line_error_next    = line_error;
    line_seen_next     = line_seen;
    leading_bytes_next = leading_bytes;

    if (step && !is_ws) begin
      if (char_code == CHAR_LF) begin
        // Line end: report unless the line was blank, then start over
        if (!(phase == PH_WAIT && !line_seen)) begin
          evt.end_valid = 1'b1;
          if (line_error == ERR_NONE && phase != PH_DONE) begin
            evt.error = ERR_SHORT;
          end
        end
        phase_next         = PH_WAIT;
        nibble_hold_next   = 4'd0;
        rec_length_next    = 8'd0;
        rec_offset_next    = 16'd0;
        rec_kind_next      = 8'd0;
        byte_index_next    = 8'd0;
        running_sum_next   = 8'd0;
        line_error_next    = ERR_NONE;
        line_seen_next     = 1'b0;
        leading_bytes_next = '0;
      end else if (phase == PH_WAIT) begin
        line_seen_next = 1'b1;
        if (char_code == CHAR_COLON) begin
          phase_next = PH_CNT_HI;
        end else begin
          line_error_next = ERR_NO_COLON;
          phase_next      = PH_ERROR;
        end
      end else if (phase == PH_DONE || phase == PH_ERROR) begin
        // trailing text ignored
      end else if (!hex_ok) begin
        line_error_next = ERR_BAD_HEX;
        phase_next      = PH_ERROR;
      end else begin
        unique case (phase)
          PH_CNT_HI, PH_AH_HI, PH_AL_HI, PH_TYP_HI, PH_DAT_HI, PH_SUM_HI: begin
            nibble_hold_next = hex_val;
            unique case (phase)
              PH_CNT_HI: phase_next = PH_CNT_LO;
              PH_AH_HI:  phase_next = PH_AH_LO;
              PH_AL_HI:  phase_next = PH_AL_LO;
              PH_TYP_HI: phase_next = PH_TYP_LO;
              PH_DAT_HI: phase_next = PH_DAT_LO;
              default:   phase_next = PH_SUM_LO;
            endcase
          end
          PH_CNT_LO: begin
            running_sum_next = sum_new;
            rec_length_next  = byte_val;
            phase_next       = PH_AH_HI;
          end
          PH_AH_LO: begin
            running_sum_next = sum_new;
            rec_offset_next  = {byte_val, 8'd0};
            phase_next       = PH_AL_HI;
          end
          PH_AL_LO: begin
            running_sum_next = sum_new;
            rec_offset_next  = {rec_offset[15:8], byte_val};
            phase_next       = PH_TYP_HI;
          end
          PH_TYP_LO: begin
            running_sum_next = sum_new;
            rec_kind_next    = byte_val;
            if (byte_val > MAX_REC_TYPE) begin
              line_error_next = ERR_TYPE;
              phase_next      = PH_ERROR;
            end else if (rec_length != 8'd0) begin
              phase_next = PH_DAT_HI;
            end else begin
              phase_next = PH_SUM_HI;
            end
          end
          PH_DAT_LO: begin
            // Data byte goes out as soon as it completes
            running_sum_next = sum_new;
            evt.data_valid   = 1'b1;
            if (byte_index[7:2] == 6'd0) begin
              leading_bytes_next[byte_index[1:0]] = byte_val;
            end
            byte_index_next = idx_inc[7:0];
            phase_next = (idx_inc >= {1'b0, rec_length}) ? PH_SUM_HI : PH_DAT_HI;
          end
          PH_SUM_LO: begin
            running_sum_next = sum_new;
            if (sum_new != 8'd0) begin
              line_error_next = ERR_CHECKSUM;
              phase_next      = PH_ERROR;
            end else begin
              phase_next = PH_DONE;
            end
          end
          default: phase_next = PH_ERROR;
        endcase
      end
    end
  end

  // Line state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_WAIT;
      nibble_hold   <= 4'd0;
      rec_length    <= 8'd0;
      rec_offset    <= 16'd0;
      rec_kind      <= 8'd0;
      byte_index    <= 8'd0;
      running_sum   <= 8'd0;
      line_error    <= ERR_NONE;
      line_seen     <= 1'b0;
      leading_bytes <= '0;
    end else begin
      phase         <= phase_next;
      nibble_hold   <= nibble_hold_next;
      rec_length    <= rec_length_next;
      rec_offset    <= rec_offset_next;
      rec_kind      <= rec_kind_next;
      byte_index    <= byte_index_next;
      running_sum   <= running_sum_next;
      line_error    <= line_error_next;
      line_seen     <= line_seen_next;
      leading_bytes <= leading_bytes_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/hrsp_file_stats.sv =====
// File-level state: base address, entry point, address range and counts.
`default_nettype none

module hrsp_file_stats (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire logic              new_file,
  input  wire hrsp_pkg::line_evt_t evt,
  output logic                   record_ok,
  output logic [31:0]            byte_address,
  output logic [31:0]            range_start,
  output logic [31:0]            range_end,
  output logic [31:0]            entry_address,
  output logic                   entry_valid,
  output logic [31:0]            data_records,
  output logic [31:0]            data_bytes
);
  import hrsp_pkg::*;

  logic [31:0] base_address, base_address_next;
  logic [31:0] lowest_address, lowest_address_next;
  logic [31:0] highest_end, highest_end_next;
  logic [31:0] exec_address, exec_address_next;
  logic        exec_valid, exec_valid_next;
  logic [31:0] record_total, record_total_next;
  logic [31:0] byte_total, byte_total_next;

  logic [31:0] base_eff, lowest_eff, highest_eff, exec_eff, rtotal_eff, btotal_eff;
  logic        exec_valid_eff;
  logic [31:0] rec_start, rec_end;
  logic [32:0] bytes_sum;
  logic        accept;

  // New file clears before the character is handled
  always_comb begin
    base_eff       = new_file ? 32'd0 : base_address;
    lowest_eff     = new_file ? COUNT_MAX : lowest_address;
    highest_eff    = new_file ? 32'd0 : highest_end;
    exec_eff       = new_file ? 32'd0 : exec_address;
    exec_valid_eff = new_file ? 1'b0 : exec_valid;
    rtotal_eff     = new_file ? 32'd0 : record_total;
    btotal_eff     = new_file ? 32'd0 : byte_total;
  end

  assign byte_address = base_eff + {16'd0, evt.offset} + {24'd0, evt.index};
  assign rec_start    = base_eff + {16'd0, evt.offset};
  assign rec_end      = rec_start + {24'd0, evt.length};
  assign bytes_sum    = {1'b0, btotal_eff} + {25'd0, evt.length};
  assign record_ok    = (evt.error == ERR_NONE);
  assign accept       = evt.end_valid && record_ok;

  // Record acceptance
  always_comb begin
    base_address_next   = base_eff;
    lowest_address_next = lowest_eff;
    highest_end_next    = highest_eff;
    exec_address_next   = exec_eff;
    exec_valid_next     = exec_valid_eff;
    record_total_next   = rtotal_eff;
    byte_total_next     = btotal_eff;
    if (accept) begin
      case (evt.kind)
        REC_DATA: begin
          if (rtotal_eff != COUNT_MAX) begin
            record_total_next = rtotal_eff + 32'd1;
          end
          byte_total_next = bytes_sum[32] ? COUNT_MAX : bytes_sum[31:0];
          if (rec_start < lowest_eff) begin
            lowest_address_next = rec_start;
          end
          if (rec_end > highest_eff) begin
            highest_end_next = rec_end;
          end
        end
        REC_LIN_ADDR: begin
          if (evt.length >= 8'd2) begin
            base_address_next = {evt.lead[0], evt.lead[1], 16'd0};
          end
        end
        REC_SEG_ADDR: begin
          if (evt.length >= 8'd2) begin
            base_address_next = {12'd0, evt.lead[0], evt.lead[1], 4'd0};
          end
        end
        REC_SEG_EXEC: begin
          if (evt.length >= 8'd4) begin
            exec_address_next = {12'd0, evt.lead[0], evt.lead[1], 4'd0} +
                                {16'd0, evt.lead[2], evt.lead[3]};
            exec_valid_next   = 1'b1;
          end
        end
        REC_LIN_EXEC: begin
          if (evt.length >= 8'd4) begin
            exec_address_next = {evt.lead[0], evt.lead[1], evt.lead[2], evt.lead[3]};
            exec_valid_next   = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Report fields show the state after this record
  assign range_start   = (record_total_next != 32'd0) ? lowest_address_next : 32'd0;
  assign range_end     = (record_total_next != 32'd0) ? highest_end_next : 32'd0;
  assign entry_address = exec_address_next;
  assign entry_valid   = exec_valid_next;
  assign data_records  = record_total_next;
  assign data_bytes    = byte_total_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address   <= 32'd0;
      lowest_address <= COUNT_MAX;
      highest_end    <= 32'd0;
      exec_address   <= 32'd0;
      exec_valid     <= 1'b0;
      record_total   <= 32'd0;
      byte_total     <= 32'd0;
    end else if (step) begin
      base_address   <= base_address_next;
      lowest_address <= lowest_address_next;
      highest_end    <= highest_end_next;
      exec_address   <= exec_address_next;
      exec_valid     <= exec_valid_next;
      record_total   <= record_total_next;
      byte_total     <= byte_total_next;
    end
  end

endmodule

`default_nettype wire

// ===== dv/hex_record_parse_checker.sv =====
// Checker for the hex record stream parser: tracks line state and compares every result.
module hex_record_parse_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  char_code,
  input  logic        new_file,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        result_kind,
  input  logic [7:0]  data_byte,
  input  logic [31:0] byte_address,
  input  logic [7:0]  record_type,
  input  logic        record_ok,
  input  logic [2:0]  error_code,
  input  logic [31:0] range_start,
  input  logic [31:0] range_end,
  input  logic [31:0] entry_address,
  input  logic        entry_valid,
  input  logic [31:0] data_records,
  input  logic [31:0] data_bytes,
  output int          bad_results,
  output int          results_owed
);
  import hrsp_pkg::*;

  // Position within one record line
  typedef enum logic [3:0] {
    PH_WAIT     = 4'd0,
    PH_LEN_HI   = 4'd1,
    PH_LEN_LO   = 4'd2,
    PH_OFS1_HI  = 4'd3,
    PH_OFS1_LO  = 4'd4,
    PH_OFS0_HI  = 4'd5,
    PH_OFS0_LO  = 4'd6,
    PH_TYPE_HI  = 4'd7,
    PH_TYPE_LO  = 4'd8,
    PH_DATA_HI  = 4'd9,
    PH_DATA_LO  = 4'd10,
    PH_SUM_HI   = 4'd11,
    PH_SUM_LO   = 4'd12,
    PH_DONE     = 4'd13,
    PH_ERROR    = 4'd14
  } phase_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data;
    logic [31:0] addr;
    logic [7:0]  rtype;
    logic        ok;
    line_err_t   err;
    logic [31:0] rstart;
    logic [31:0] rend;
    logic [31:0] entry;
    logic        entry_ok;
    logic [31:0] nrec;
    logic [31:0] nbytes;
  } parse_result_t;

  // Line state
  phase_t      phase;
  logic [3:0]  nib;
  logic [7:0]  len_r;
  logic [15:0] offs_r;
  logic [7:0]  kind_r;
  logic [7:0]  idx;
  logic [7:0]  sum;
  line_err_t   line_err;
  logic        line_started;
  logic [7:0]  lead [4];

  // File state
  logic [31:0] base;
  logic [31:0] low_addr;
  logic [31:0] high_end;
  logic [31:0] entry;
  logic        entry_ok;
  logic [31:0] rec_count;
  logic [31:0] byte_count;

  parse_result_t parsed_results [$];
  int mismatches = 0;

  function automatic void clear_line();
    phase = PH_WAIT;
    nib = '0;
    len_r = '0;
    offs_r = '0;
    kind_r = '0;
    idx = '0;
    sum = '0;
    line_err = ERR_NONE;
    line_started = 1'b0;
    foreach (lead[i]) lead[i] = 8'h00;
  endfunction

  function automatic void clear_file();
    base = '0;
    low_addr = COUNT_MAX;
    high_end = '0;
    entry = '0;
    entry_ok = 1'b0;
    rec_count = '0;
    byte_count = '0;
  endfunction

  function automatic int digit_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    return -1;
  endfunction

  // Apply a record that passed every check to the file state
  function automatic void commit_record();
    logic [31:0] start;
    logic [31:0] stop;
    logic [32:0] total;
    case (kind_r)
      REC_DATA: begin
        start = base + {16'h0, offs_r};
        stop = start + {24'h0, len_r};
        total = {1'b0, byte_count} + {25'h0, len_r};
        if (rec_count != COUNT_MAX) rec_count = rec_count + 1;
        byte_count = total[32] ? COUNT_MAX : total[31:0];
        if (start < low_addr) low_addr = start;
        if (stop > high_end) high_end = stop;
      end
      REC_LIN_ADDR: begin
        if (len_r >= 8'd2) base = {lead[0], lead[1], 16'h0};
      end
      REC_SEG_ADDR: begin
        if (len_r >= 8'd2) base = {12'h0, lead[0], lead[1], 4'h0};
      end
      REC_SEG_EXEC: begin
        if (len_r >= 8'd4) begin
          entry = {12'h0, lead[0], lead[1], 4'h0} + {16'h0, lead[2], lead[3]};
          entry_ok = 1'b1;
        end
      end
      REC_LIN_EXEC: begin
        if (len_r >= 8'd4) begin
          entry = {lead[0], lead[1], lead[2], lead[3]};
          entry_ok = 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  // Advance the line state by one character; returns 1 when it yields a result
  function automatic bit parse_char(input logic [7:0] c, input logic nf,
                                    output parse_result_t r);
    int d;
    logic [7:0] b;
    line_err_t e;
    r = '0;
    if (nf) clear_file();
    if (c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_CR) return 0;

    // End of line: report unless the line was blank
    if (c == CHAR_LF) begin
      if (phase == PH_WAIT && !line_started) return 0;
      e = line_err;
      if (e == ERR_NONE && phase != PH_DONE) e = ERR_SHORT;
      if (e == ERR_NONE) commit_record();
      r.kind = RESULT_REPORT;
      r.rtype = kind_r;
      r.ok = (e == ERR_NONE);
      r.err = e;
      r.rstart = (rec_count != 0) ? low_addr : 32'h0;
      r.rend = (rec_count != 0) ? high_end : 32'h0;
      r.entry = entry;
      r.entry_ok = entry_ok;
      r.nrec = rec_count;
      r.nbytes = byte_count;
      clear_line();
      return 1;
    end

    if (phase == PH_WAIT) begin
      line_started = 1'b1;
      if (c == CHAR_COLON) begin
        phase = PH_LEN_HI;
      end else begin
        line_err = ERR_NO_COLON;
        phase = PH_ERROR;
      end
      return 0;
    end
    if (phase == PH_DONE || phase == PH_ERROR) return 0;

    d = digit_value(c);
    if (d < 0) begin
      line_err = ERR_BAD_HEX;
      phase = PH_ERROR;
      return 0;
    end
    if (phase[0]) begin
      nib = d[3:0];
      phase = phase_t'(phase + 4'd1);
      return 0;
    end

    // Second digit completes a byte
    b = {nib, d[3:0]};
    sum = sum + b;
    case (phase)
      PH_LEN_LO: begin
        len_r = b;
        phase = PH_OFS1_HI;
      end
      PH_OFS1_LO: begin
        offs_r = {b, 8'h00};
        phase = PH_OFS0_HI;
      end
      PH_OFS0_LO: begin
        offs_r[7:0] = b;
        phase = PH_TYPE_HI;
      end
      PH_TYPE_LO: begin
        kind_r = b;
        if (b > MAX_REC_TYPE) begin
          line_err = ERR_TYPE;
          phase = PH_ERROR;
        end else begin
          phase = (len_r != 0) ? PH_DATA_HI : PH_SUM_HI;
        end
      end
      PH_DATA_LO: begin
        r.kind = RESULT_DATA;
        r.data = b;
        r.addr = base + {16'h0, offs_r} + {24'h0, idx};
        r.rtype = kind_r;
        if (idx < 8'd4) lead[idx[1:0]] = b;
        idx = idx + 8'd1;
        phase = (idx >= len_r) ? PH_SUM_HI : PH_DATA_HI;
        return 1;
      end
      default: begin
        if (sum != 8'h00) begin
          line_err = ERR_CHECKSUM;
          phase = PH_ERROR;
        end else begin
          phase = PH_DONE;
        end
      end
    endcase
    return 0;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  // Results are checked before the new character is parsed; latency keeps them apart
  always @(posedge clk) begin : track
    parse_result_t due;
    parse_result_t fresh;
    if (rst) begin
      clear_line();
      clear_file();
      parsed_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (parsed_results.size() == 0) begin
          $error("result with nothing outstanding: kind %0d byte %0h", result_kind,
                 data_byte);
          mismatches++;
        end else begin
          due = parsed_results.pop_front();
          compare_field("result_kind", due.kind, result_kind);
          compare_field("data_byte", due.data, data_byte);
          compare_field("byte_address", due.addr, byte_address);
          compare_field("record_type", due.rtype, record_type);
          compare_field("record_ok", due.ok, record_ok);
          compare_field("error_code", due.err, error_code);
          compare_field("range_start", due.rstart, range_start);
          compare_field("range_end", due.rend, range_end);
          compare_field("entry_address", due.entry, entry_address);
          compare_field("entry_valid", due.entry_ok, entry_valid);
          compare_field("data_records", due.nrec, data_records);
          compare_field("data_bytes", due.nbytes, data_bytes);
        end
      end
      if (in_valid && in_ready) begin
        if (parse_char(char_code, new_file, fresh)) parsed_results.push_back(fresh);
      end
    end
    results_owed <= parsed_results.size();
    bad_results <= mismatches;
  end

endmodule

// ===== dv/hex_record_stream_parser_test.sv =====
// Testbench top for the hex record stream parser: hex text stimulus, flow control, verdict.
module hex_record_stream_parser_test;
  import hrsp_pkg::*;

  localparam logic [7:0] REC_EOF = 8'h01;
  localparam int ITEM_TARGET = 1350;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 10;
  localparam int HOLD_CYCLES = 120;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  char_code = 8'h00;
  logic        new_file = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        result_kind;
  logic [7:0]  data_byte;
  logic [31:0] byte_address;
  logic [7:0]  record_type;
  logic        record_ok;
  logic [2:0]  error_code;
  logic [31:0] range_start;
  logic [31:0] range_end;
  logic [31:0] entry_address;
  logic        entry_valid;
  logic [31:0] data_records;
  logic [31:0] data_bytes;
  int          bad_results;
  int          results_owed;

  int          chars_sent = 0;
  int          chars_taken = 0;
  int          burst_left = 0;
  int          idle_cycles = 0;
  int          colon_at;
  logic [7:0]  line_chars [$];
  logic [7:0]  payload [$];

  hex_record_stream_parser DUT (.*);

  hex_record_parse_checker watcher (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Stall watchdog: no transaction on either channel for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (in_valid && in_ready) chars_taken <= chars_taken + 1;
  end

  function automatic logic [7:0] ws_char();
    case ($urandom_range(0, 2))
      0: return CHAR_SPACE;
      1: return CHAR_TAB;
      default: return CHAR_CR;
    endcase
  endfunction

  // Random character other than LF and whitespace, optionally also not hex or colon
  function automatic logic [7:0] pick_char(input bit no_hex, input bit no_colon);
    logic [7:0] c;
    bit hexish;
    do begin
      c = 8'($urandom_range(0, 255));
      hexish = (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
    end while (c == CHAR_LF || c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_CR ||
               (no_hex && hexish) || (no_colon && c == CHAR_COLON));
    return c;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return "0" + n;
    return (($urandom_range(0, 3) == 0) ? "a" : "A") + n - 8'd10;
  endfunction

  // Two digits, with an occasional whitespace character slipped in
  task automatic push_hex(input logic [7:0] b);
    line_chars.push_back(hex_char(b[7:4]));
    if ($urandom_range(0, 24) == 0) line_chars.push_back(ws_char());
    line_chars.push_back(hex_char(b[3:0]));
    if ($urandom_range(0, 24) == 0) line_chars.push_back(ws_char());
  endtask

  // Record text without the LF; payload bytes are used first, then random ones
  task automatic build_record(input logic [7:0] kind, input logic [7:0] len,
                              input int nbytes, input logic [15:0] offs, input bit bad_sum);
    logic [7:0] sum;
    logic [7:0] b;
    if ($urandom_range(0, 9) == 0) line_chars.push_back(ws_char());
    colon_at = line_chars.size();
    line_chars.push_back(CHAR_COLON);
    sum = len + offs[15:8] + offs[7:0] + kind;
    push_hex(len);
    push_hex(offs[15:8]);
    push_hex(offs[7:0]);
    push_hex(kind);
    for (int i = 0; i < nbytes; i++) begin
      b = (i < payload.size()) ? payload[i] : 8'($urandom);
      push_hex(b);
      sum = sum + b;
    end
    sum = ~sum + 8'd1;
    if (bad_sum) sum = sum ^ 8'($urandom_range(1, 255));
    push_hex(sum);
    payload.delete();
  endtask

  // One transaction on the input channel, in bursts with gaps between them
  task automatic send_char(input logic [7:0] c, input bit nf);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    char_code <= c;
    new_file <= nf;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_line();
    bit fresh_file;
    fresh_file = ($urandom_range(0, 11) == 0);
    foreach (line_chars[i])
      send_char(line_chars[i], (i == 0 && fresh_file) || $urandom_range(0, 199) == 0);
    line_chars.delete();
  endtask

  // Mostly well-formed records, some blank, noisy or damaged lines
  task automatic random_line();
    int pick;
    int nbytes;
    int flaw;
    int cut;
    logic [7:0] kind;
    logic [7:0] len;
    logic [15:0] offs;
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      repeat ($urandom_range(0, 3)) line_chars.push_back(ws_char());
    end else if (pick < 10) begin
      repeat ($urandom_range(1, 8)) line_chars.push_back(pick_char(0, 0));
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 50) kind = REC_DATA;
      else if (pick < 58) kind = REC_EOF;
      else if (pick < 66) kind = REC_SEG_ADDR;
      else if (pick < 74) kind = REC_SEG_EXEC;
      else if (pick < 84) kind = REC_LIN_ADDR;
      else if (pick < 92) kind = REC_LIN_EXEC;
      else kind = 8'($urandom_range(6, 255));
      case (kind)
        REC_DATA:
          len = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(17, 255))
                                              : 8'($urandom_range(0, 16));
        REC_SEG_ADDR, REC_LIN_ADDR:
          len = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 3)) : 8'd2;
        REC_SEG_EXEC, REC_LIN_EXEC:
          len = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 5)) : 8'd4;
        REC_EOF:
          len = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 3)) : 8'd0;
        default:
          len = 8'($urandom);
      endcase
      // a bad type stops parsing, so a long body would only waste characters
      nbytes = (kind > MAX_REC_TYPE && len > 8'd2) ? 2 : int'(len);
      if ($urandom_range(0, 7) == 0) offs = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      else offs = 16'($urandom);
      if (kind != REC_DATA && $urandom_range(0, 2) == 0) payload.push_back(8'hFF);
      build_record(kind, len, nbytes, offs, $urandom_range(0, 11) == 0);
      flaw = $urandom_range(0, 19);
      if (flaw == 0) begin
        line_chars[colon_at] = pick_char(0, 1);
      end else if (flaw == 1) begin
        line_chars[$urandom_range(colon_at + 1, line_chars.size() - 1)] = pick_char(1, 0);
      end else if (flaw == 2) begin
        cut = $urandom_range(colon_at + 1, line_chars.size() - 1);
        while (line_chars.size() > cut) void'(line_chars.pop_back());
      end else if (flaw <= 4) begin
        repeat ($urandom_range(1, 4)) line_chars.push_back(pick_char(0, 0));
      end
    end
    line_chars.push_back(CHAR_LF);
    send_line();
  endtask

  // Output flow control: mixed stall patterns plus one long hold-off
  initial begin : receiver
    int seg;
    int mode;
    bit held;
    held = 1'b0;
    forever begin
      if (!held && chars_taken >= 400) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      seg = $urandom_range(8, 60);
      for (int i = 0; i < seg; i++) begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= (i % 4 != 3);
          default: out_ready <= ($urandom_range(0, 4) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Blank lines, whitespace only and a bare LF
    line_chars = '{CHAR_SPACE, CHAR_TAB, CHAR_CR, CHAR_LF};
    send_line();
    line_chars = '{CHAR_LF};
    send_line();
    // Linear base at the top of memory, then data that wraps the address space
    payload = '{8'hFF, 8'hFF};
    build_record(REC_LIN_ADDR, 8'd2, 2, 16'h0000, 1'b0);
    line_chars.push_back(CHAR_LF);
    send_line();
    payload = '{8'h00, 8'hFF};
    build_record(REC_DATA, 8'd2, 2, 16'hFFFF, 1'b0);
    line_chars.push_back(CHAR_LF);
    send_line();
    // Missing start mark
    line_chars = '{"G", CHAR_LF};
    send_line();
    // Linear entry point, all ones
    payload = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
    build_record(REC_LIN_EXEC, 8'd4, 4, 16'h0000, 1'b0);
    line_chars.push_back(CHAR_LF);
    send_line();

    while (chars_sent < ITEM_TARGET) random_line();
    in_valid <= 1'b0;

    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (bad_results == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
